FILE: design/mwc_pkg.sv
// shared types and constants of the lag-256 multiply-with-carry generator
// no dependencies; imported by every module of the block but mwc_ram
package mwc_pkg;

    // store geometry
    localparam int LAG_DEPTH      = 256;
    localparam int LAG_AW         = 8;
    localparam int SEED_WORDS_DEF = 16;

    // payload widths
    localparam int WORD_W  = 32;
    localparam int CARRY_W = 30;
    localparam int MULK_W  = 30;
    localparam int PROD_W  = MULK_W + WORD_W;
    localparam int FUNC_W  = 2;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_SEED   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESEED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GEN    = 2'd2;

    // generator constants
    localparam logic [MULK_W-1:0]  MUL_A       = 30'd809430660;
    localparam logic [MULK_W-1:0]  CHAIN_MUL   = 30'd69069;
    localparam logic [WORD_W-1:0]  CHAIN_ADD   = 32'd764385;
    localparam logic [WORD_W-1:0]  CHAIN_START = 32'd232497429;
    localparam logic [CARRY_W-1:0] CARRY_INIT  = 30'd362436;
    localparam logic [LAG_AW-1:0]  LAST_IDX    = 8'd255;

    // control of the shared multiply-add unit
    typedef struct packed {
        logic load;   // capture a new product
        logic lcg;    // chain constants instead of the mwc multiplier
    } t_mac_ctl;

endpackage

FILE: design/mwc_ram.sv
// simple dual-port ram: one write port, one registered read port
// depends on nothing; used for the lag store and the seed store
module mwc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mwc_mac.sv
// shared two-stage multiply-add unit: product register, then add of the addend
// depends on mwc_pkg for widths, constants and the control struct
module mwc_mac (
    input  logic                        i_clk,
    input  mwc_pkg::t_mac_ctl           i_ctl,
    input  logic [mwc_pkg::WORD_W-1:0]  i_op,
    input  logic [mwc_pkg::WORD_W-1:0]  i_addend,
    output logic [mwc_pkg::PROD_W-1:0]  o_sum
);
    import mwc_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic              r_lcg;
    logic [MULK_W-1:0] k;

    // multiplier constant select
    assign k = i_ctl.lcg ? CHAIN_MUL : MUL_A;

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= {{WORD_W{1'b0}}, k} * {{MULK_W{1'b0}}, i_op};
            r_lcg  <= i_ctl.lcg;
        end
    end

    // add stage: carry for mwc steps, chain increment plus seed word for the lcg
    assign o_sum = r_prod + {{MULK_W{1'b0}}, i_addend}
                 + (r_lcg ? {{MULK_W{1'b0}}, CHAIN_ADD} : {PROD_W{1'b0}});

endmodule

FILE: design/mwc_lag256_generator.sv
// top level of the lag-256 multiply-with-carry generator: sequencer and stores
// depends on mwc_pkg, mwc_ram and mwc_mac
//
// A request is taken at a clock edge with start high and busy low. A generate
// request runs a multiply in the shared unit, then the carry add and store
// write, and its word appears on o_random_word for exactly one cycle with
// o_strobe high; there is no way to hold it, so the receiver must take it then.
// A seed or reseed word without the last flag leaves the block idle. The word
// with the last flag starts a pass over all 256 store entries, each through
// S_SW_A and S_SW_B, limited by the chained lcg going through the shared
// multiplier, then a fetch state; busy stays high until it is back in idle.
// After reset the store is cleared one entry per cycle and fetched, under busy.
module mwc_lag256_generator #(
    parameter int SEED_WORDS = mwc_pkg::SEED_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mwc_pkg::FUNC_W-1:0]  i_func,
    input  logic [mwc_pkg::WORD_W-1:0]  i_seed_word,
    input  logic                        i_seed_last,
    output logic                        o_strobe,
    output logic [mwc_pkg::WORD_W-1:0]  o_random_word
);
    import mwc_pkg::*;

    localparam int SEED_AW = (SEED_WORDS > 1) ? $clog2(SEED_WORDS) : 1;
    localparam int CNT_W   = $clog2(SEED_WORDS + 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_FETCH = 6'b000010,
        S_IDLE  = 6'b000100,
        S_GEN   = 6'b001000,
        S_SW_A  = 6'b010000,
        S_SW_B  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [LAG_AW-1:0]    r_i, n_i;
    logic [LAG_AW-1:0]    r_idx, n_idx;
    logic [SEED_AW-1:0]   r_j, n_j;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [WORD_W-1:0]    r_x, n_x;
    logic [CARRY_W-1:0]   r_carry, n_carry;
    logic                 r_rebuild, n_rebuild;
    logic                 r_strobe, n_strobe;
    logic [WORD_W-1:0]    r_word, n_word;

    logic                 lag_we;
    logic [LAG_AW-1:0]    lag_waddr, lag_raddr;
    logic [WORD_W-1:0]    lag_wdata, lag_rdata;
    logic                 seed_we;
    logic [SEED_AW-1:0]   seed_waddr, seed_raddr;
    logic [WORD_W-1:0]    seed_rdata;
    t_mac_ctl             mac_ctl;
    logic [WORD_W-1:0]    mac_op, mac_add;
    logic [PROD_W-1:0]    mac_sum;
    logic [CNT_W-1:0]     j_inc;
    logic                 is_seed;

    // lag store
    mwc_ram #(.DEPTH(LAG_DEPTH), .WIDTH(WORD_W), .AW(LAG_AW)) u_lag (
        .i_clk   (i_clk),
        .i_we    (lag_we),
        .i_waddr (lag_waddr),
        .i_wdata (lag_wdata),
        .i_raddr (lag_raddr),
        .o_rdata (lag_rdata)
    );

    // seed word store
    mwc_ram #(.DEPTH(SEED_WORDS), .WIDTH(WORD_W), .AW(SEED_AW)) u_seed (
        .i_clk   (i_clk),
        .i_we    (seed_we),
        .i_waddr (seed_waddr),
        .i_wdata (i_seed_word),
        .i_raddr (seed_raddr),
        .o_rdata (seed_rdata)
    );

    // shared multiply-add
    mwc_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_op     (mac_op),
        .i_addend (mac_add),
        .o_sum    (mac_sum)
    );

    assign is_seed = (i_func == FUNC_SEED) || (i_func == FUNC_RESEED);
    assign j_inc   = CNT_W'(r_j) + CNT_W'(1);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_idx      = r_idx;
        n_j        = r_j;
        n_count    = r_count;
        n_x        = r_x;
        n_carry    = r_carry;
        n_rebuild  = r_rebuild;
        n_strobe   = 1'b0;
        n_word     = r_word;
        lag_we     = 1'b0;
        lag_waddr  = r_i;
        lag_wdata  = '0;
        lag_raddr  = r_idx;
        seed_we    = 1'b0;
        seed_waddr = SEED_AW'(r_count);
        seed_raddr = r_j;
        mac_ctl    = '{load: 1'b0, lcg: 1'b0};
        mac_op     = lag_rdata;
        mac_add    = WORD_W'(r_carry);
        unique case (r_state)
            S_CLEAR: begin
                lag_we = 1'b1;
                n_i    = r_i + 1'b1;
                if (r_i == LAST_IDX) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start && (i_func == FUNC_GEN)) begin
                    mac_ctl.load = 1'b1;
                    n_state      = S_GEN;
                end else if (start && is_seed) begin
                    if (r_count < CNT_W'(SEED_WORDS)) begin
                        seed_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    if (i_seed_last) begin
                        n_rebuild = (i_func == FUNC_SEED);
                        n_i       = '0;
                        n_j       = '0;
                        n_x       = CHAIN_START;
                        n_state   = S_SW_A;
                    end
                end
            end
            S_GEN: begin
                lag_we    = 1'b1;
                lag_waddr = r_idx;
                lag_wdata = mac_sum[WORD_W-1:0];
                n_carry   = mac_sum[PROD_W-1:WORD_W];
                n_strobe  = 1'b1;
                n_word    = mac_sum[WORD_W-1:0];
                n_idx     = r_idx - 1'b1;
                // prefetch the next entry so the next request can start at once
                lag_raddr = r_idx - 1'b1;
                n_state   = S_IDLE;
            end
            S_SW_A: begin
                lag_raddr = r_i;
                mac_ctl   = '{load: 1'b1, lcg: 1'b1};
                mac_op    = r_x;
                n_state   = S_SW_B;
            end
            S_SW_B: begin
                mac_add   = seed_rdata;
                lag_we    = 1'b1;
                lag_wdata = r_rebuild ? mac_sum[WORD_W-1:0] : (lag_rdata ^ seed_rdata);
                n_x       = mac_sum[WORD_W-1:0];
                n_i       = r_i + 1'b1;
                n_j       = (j_inc >= r_count) ? '0 : SEED_AW'(j_inc);
                if (r_i == LAST_IDX) begin
                    n_idx   = LAST_IDX;
                    n_count = '0;
                    if (r_rebuild) begin
                        n_carry = CARRY_INIT;
                    end
                    n_state = S_FETCH;
                end else begin
                    n_state = S_SW_A;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_i      <= '0;
            r_idx    <= LAST_IDX;
            r_count  <= '0;
            r_carry  <= CARRY_INIT;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_carry  <= n_carry;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_x       <= n_x;
        r_rebuild <= n_rebuild;
        r_word    <= n_word;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_random_word = r_word;

endmodule

FILE: design/mwc_checker.sv
// port-level checker for the lag-256 multiply-with-carry generator, with its bind
// depends on mwc_pkg and on the port list of mwc_lag256_generator
module mwc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [mwc_pkg::FUNC_W-1:0]  i_func,
    input logic                        i_seed_last,
    input logic                        o_strobe
);
    import mwc_pkg::*;

    logic gen_req;
    logic last_req;

    assign gen_req  = start && !busy && (i_func == FUNC_GEN);
    assign last_req = start && !busy && i_seed_last
                    && ((i_func == FUNC_SEED) || (i_func == FUNC_RESEED));

    // every generate request yields a word, through the S_GEN state and the strobe register
    a_gen_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_req |-> ##2 o_strobe)
        else $error("generate request without a result");

    // no word appears without a generate request ahead of it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(gen_req, 2))
        else $error("result without a generate request");

    // a result is shown as the block becomes free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result while busy");

    // the last seed word starts a store pass that keeps the block busy
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_req |=> busy ##1 busy)
        else $error("store pass did not hold busy");

endmodule

bind mwc_lag256_generator mwc_checker u_mwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_func      (i_func),
    .i_seed_last (i_seed_last),
    .o_strobe    (o_strobe)
);
